// ===== design/bigram_index_cipher_core_defines.svh =====
// Assertion macros used by the checker file of the bigram index cipher core.
`ifndef BIGRAM_INDEX_CIPHER_CORE_DEFINES_SVH
`define BIGRAM_INDEX_CIPHER_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bic_pkg.sv =====
// Shared types, constants and register codes of the bigram index cipher core.
package bic_pkg;

    localparam int ALPHABET_MAX_DEF = 32;

    localparam int CHAR_W    = 8;
    localparam int CODE_W    = 10;
    localparam int POS_W     = 5;
    localparam int CNT_W     = 3;
    localparam int ALU_W     = 11;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WORD0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd5;

    // Word 0 holds alphabet entries 0 to 7, entry 0 in the low byte.
    localparam logic [3:0][CFG_W-1:0] ALPHA_RESET = {
        64'd23129,
        64'd6365651522798441041,
        64'd5786930140093827657,
        64'd5208208757389214273
    };
    localparam logic [POS_W-1:0]  LEN_RESET = 5'd26;
    localparam logic [CHAR_W-1:0] PAD_RESET = 8'd90;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;
    localparam logic KIND_CODE   = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              action;
        logic [CHAR_W-1:0] symbol;
        logic [CODE_W-1:0] code_in;
        logic              message_end;
    } in_item_t;

    typedef struct packed {
        logic              out_kind;
        logic [CODE_W-1:0] out_code;
        logic [CHAR_W-1:0] out_char;
        logic              bad_code;
        logic              run_last;
    } out_item_t;

endpackage

// ===== design/bic_alu.sv =====
// Shared add/subtract unit used by the multiply, final add and divide sequences.
module bic_alu (
    input  bic_pkg::alu_req_t           req,
    output logic [bic_pkg::ALU_W-1:0]   result,
    output logic                        no_borrow
);
    import bic_pkg::*;

    logic [ALU_W:0] wide;

    always_comb
    begin
        case (req.op)
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default: wide = '0;
        endcase
    end

    assign result    = wide[ALU_W-1:0];
    assign no_borrow = ~wide[ALU_W];

endmodule

// ===== design/bic_pos_find.sv =====
// Alphabet position search: lowest matching entry below the active length, else zero.
module bic_pos_find #(
    parameter int ALPHABET_MAX = bic_pkg::ALPHABET_MAX_DEF
) (
    input  logic [ALPHABET_MAX-1:0][bic_pkg::CHAR_W-1:0] alpha,
    input  logic [bic_pkg::POS_W-1:0]                    n_eff,
    input  logic [bic_pkg::CHAR_W-1:0]                   ch,
    output logic [bic_pkg::POS_W-1:0]                    pos
);
    import bic_pkg::*;

    // Scanning from the top down lets the lowest match win.
    always_comb
    begin
        pos = '0;
        for (int i = ALPHABET_MAX - 2; i >= 0; i--)
        begin
            if ((POS_W'(i) < n_eff) && (alpha[i] == ch))
            begin
                pos = POS_W'(i);
            end
        end
    end

endmodule

// ===== design/bic_cfg_regs.sv =====
// Configuration registers: alphabet bytes, active length and pad character.
module bic_cfg_regs #(
    parameter int ALPHABET_MAX = bic_pkg::ALPHABET_MAX_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [bic_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [bic_pkg::CFG_W-1:0]                    cfg_data,
    output logic [ALPHABET_MAX-1:0][bic_pkg::CHAR_W-1:0] alpha,
    output logic [bic_pkg::POS_W-1:0]                    n_eff,
    output logic [bic_pkg::CHAR_W-1:0]                   pad
);
    import bic_pkg::*;

    localparam logic [POS_W-1:0] LEN_CAP = POS_W'(ALPHABET_MAX - 1);

    logic [ALPHABET_MAX-1:0][CHAR_W-1:0] alpha_reg;
    logic [POS_W-1:0]                    len_reg;
    logic [CHAR_W-1:0]                   pad_reg;

    // Entries at or above the largest usable length can never be read,
    // so only the first ALPHABET_MAX bytes of the four words are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_MAX; i++)
            begin
                alpha_reg[i] <= ALPHA_RESET[i / 8][8 * (i % 8) +: CHAR_W];
            end
            len_reg <= LEN_RESET;
            pad_reg <= PAD_RESET;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < ALPHABET_MAX; i++)
            begin
                if (cfg_index == (REG_WORD0 + CFG_IDX_W'(i / 8)))
                begin
                    alpha_reg[i] <= cfg_data[8 * (i % 8) +: CHAR_W];
                end
            end
            if (cfg_index == REG_LENGTH)
            begin
                len_reg <= cfg_data[POS_W-1:0];
            end
            if (cfg_index == REG_PAD)
            begin
                pad_reg <= cfg_data[CHAR_W-1:0];
            end
        end
    end

    assign alpha = alpha_reg;
    assign n_eff = (len_reg > LEN_CAP) ? LEN_CAP : len_reg;
    assign pad   = pad_reg;

endmodule

// ===== design/bigram_index_cipher_core.sv =====
// Bigram index cipher core: a sequencer around one shared add/subtract unit.
// A pair looks up both positions (S_LKA, S_LKB), then runs the 5-step multiply (S_MUL),
// the add (S_ADD) and the code output (S_EMIT_CODE); a decrypt code runs the 6-step restoring
// divide (S_DIV), left early when the quotient reaches 32 and skipped at zero length, then its
// characters (S_EMIT_Q, S_EMIT_R). Only S_IDLE takes requests; a held character stays there.
// Reset clears the held character and restores the configuration register defaults.
module bigram_index_cipher_core #(
    parameter int ALPHABET_MAX = bic_pkg::ALPHABET_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bic_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bic_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [bic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bic_pkg::CFG_W-1:0]     cfg_data
);
    import bic_pkg::*;

    localparam int IDX_W = $clog2(ALPHABET_MAX);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LKA,
        S_LKB,
        S_MUL,
        S_ADD,
        S_DIV,
        S_EMIT_CODE,
        S_EMIT_Q,
        S_EMIT_R
    } state_t;

    state_t             state_reg, state_next;
    logic [CHAR_W-1:0]  held_char_reg, held_char_next;
    logic               held_valid_reg, held_valid_next;
    logic [CHAR_W-1:0]  first_reg, first_next;
    logic [CHAR_W-1:0]  second_reg, second_next;
    logic [POS_W-1:0]   pos_a_reg, pos_a_next;
    logic [POS_W-1:0]   pos_b_reg, pos_b_next;
    logic [ALU_W-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               bad_reg, bad_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [ALPHABET_MAX-1:0][CHAR_W-1:0] alpha;
    logic [POS_W-1:0]   n_eff;
    logic [CHAR_W-1:0]  pad;
    logic [CHAR_W-1:0]  find_ch;
    logic [POS_W-1:0]   find_pos;
    alu_req_t           alu_req;
    logic [ALU_W-1:0]   alu_res;
    logic               alu_no_borrow;
    logic [POS_W-1:0]   rd_idx;
    logic [CHAR_W-1:0]  alpha_rd;
    logic               out_free;
    logic               bad_now;

    bic_cfg_regs #(
        .ALPHABET_MAX(ALPHABET_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .alpha    (alpha),
        .n_eff    (n_eff),
        .pad      (pad)
    );

    bic_pos_find #(
        .ALPHABET_MAX(ALPHABET_MAX)
    ) u_find (
        .alpha(alpha),
        .n_eff(n_eff),
        .ch   (find_ch),
        .pos  (find_pos)
    );

    bic_alu u_alu (
        .req      (alu_req),
        .result   (alu_res),
        .no_borrow(alu_no_borrow)
    );

    assign find_ch  = (state_reg == S_LKA) ? first_reg : second_reg;
    assign rd_idx   = (state_reg == S_EMIT_Q) ? quo_reg : acc_reg[POS_W-1:0];
    assign alpha_rd = alpha[rd_idx[IDX_W-1:0]];
    assign out_free = ~out_valid_reg | out_ready;
    assign bad_now  = bad_reg | (quo_reg >= n_eff);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
        case (state_reg)
            S_MUL:
            begin
                // Horner step: acc = 2 * acc + bit * length.
                alu_req.op = ALU_ADD;
                alu_req.a  = {acc_reg[ALU_W-2:0], 1'b0};
                alu_req.b  = pos_a_reg[cnt_reg] ? ALU_W'(n_eff) : '0;
            end
            S_ADD:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = ALU_W'(pos_b_reg);
            end
            S_DIV:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = acc_reg;
                alu_req.b  = ALU_W'(n_eff) << cnt_reg;
            end
            default:
            begin
                alu_req = '{op: ALU_ADD, a: '0, b: '0};
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        pos_a_next      = pos_a_reg;
        pos_b_next      = pos_b_reg;
        acc_next        = acc_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        bad_next        = bad_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg & ~out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.action == ACT_ENCRYPT)
                    begin
                        if (held_valid_reg)
                        begin
                            first_next      = held_char_reg;
                            second_next     = in_data.symbol;
                            held_valid_next = 1'b0;
                            state_next      = S_LKA;
                        end
                        else if (in_data.message_end)
                        begin
                            first_next  = in_data.symbol;
                            second_next = pad;
                            state_next  = S_LKA;
                        end
                        else
                        begin
                            held_char_next  = in_data.symbol;
                            held_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next = ALU_W'(in_data.code_in);
                        quo_next = '0;
                        cnt_next = CNT_W'(POS_W);
                        // A zero length makes every code invalid.
                        bad_next   = (n_eff == '0);
                        state_next = (n_eff == '0) ? S_EMIT_Q : S_DIV;
                    end
                end
            end
            S_LKA:
            begin
                pos_a_next = find_pos;
                state_next = S_LKB;
            end
            S_LKB:
            begin
                pos_b_next = find_pos;
                acc_next   = '0;
                cnt_next   = CNT_W'(POS_W - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                acc_next = alu_res;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                acc_next   = alu_res;
                state_next = S_EMIT_CODE;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(POS_W))
                begin
                    // A quotient of 32 or more is past any usable length.
                    if (alu_no_borrow)
                    begin
                        bad_next   = 1'b1;
                        state_next = S_EMIT_Q;
                    end
                end
                else
                begin
                    if (alu_no_borrow)
                    begin
                        acc_next          = alu_res;
                        quo_next[cnt_reg] = 1'b1;
                    end
                    if (cnt_reg == '0)
                    begin
                        state_next = S_EMIT_Q;
                    end
                end
            end
            S_EMIT_CODE:
            begin
                if (out_free)
                begin
                    out_next = '{out_kind: KIND_CODE, out_code: acc_reg[CODE_W-1:0],
                                 out_char: '0, bad_code: 1'b0, run_last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_Q:
            begin
                if (out_free)
                begin
                    out_next = '{out_kind: KIND_CHAR, out_code: '0,
                                 out_char: bad_now ? pad : alpha_rd,
                                 bad_code: bad_now, run_last: 1'b0};
                    out_valid_next = 1'b1;
                    bad_next       = bad_now;
                    state_next     = S_EMIT_R;
                end
            end
            S_EMIT_R:
            begin
                if (out_free)
                begin
                    out_next = '{out_kind: KIND_CHAR, out_code: '0,
                                 out_char: bad_reg ? pad : alpha_rd,
                                 bad_code: bad_reg, run_last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            bad_reg        <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            bad_reg        <= bad_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
        pos_a_reg  <= pos_a_next;
        pos_b_reg  <= pos_b_next;
        acc_reg    <= acc_next;
        quo_reg    <= quo_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== design/bic_checker.sv =====
// Port-level checks of the bigram index cipher core, bound to the top level.
`include "bigram_index_cipher_core_defines.svh"

module bic_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input bic_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input bic_pkg::out_item_t out_data
);
    import bic_pkg::*;

    // A decrypt request drops in_ready right after it is accepted, as the core leaves S_IDLE.
    `BIC_ASSERT_NEXT(a_decrypt_busy, in_valid && in_ready && (in_data.action == ACT_DECRYPT), !in_ready, "core ready right after a decrypt request")

    `BIC_ASSERT_IMP(a_code_shape, out_valid && (out_data.out_kind == KIND_CODE), out_data.run_last && !out_data.bad_code && (out_data.out_char == '0) && (out_data.out_code <= 10'd960), "malformed code result")

    `BIC_ASSERT_IMP(a_char_shape, out_valid && (out_data.out_kind == KIND_CHAR), out_data.out_code == '0, "character result carries a code")

    `BIC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind bigram_index_cipher_core bic_checker u_bic_checker (.*);
